// ===== rtl/sdfpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdfpd_pkg;

  localparam int unsigned SQRT_STEPS = 22;
  localparam int unsigned PIPE_DEPTH = 2 * SQRT_STEPS + 9;

  localparam logic [23:0] NONE_DISTANCE = 24'd25600;

  localparam logic [2:0] REG_SHAPE_KIND   = 3'd0;
  localparam logic [2:0] REG_ORIGIN       = 3'd1;
  localparam logic [2:0] REG_ROT_ROW_ZERO = 3'd2;
  localparam logic [2:0] REG_ROT_ROW_ONE  = 3'd3;
  localparam logic [2:0] REG_ROT_ROW_TWO  = 3'd4;
  localparam logic [2:0] REG_MAJOR_RADIUS = 3'd5;
  localparam logic [2:0] REG_MINOR_RADIUS = 3'd6;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_FLOOR  = 2'd2,
    KIND_TORUS  = 2'd3
  } shape_kind_e;

  typedef struct packed {
    logic signed [15:0] pos_z;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } sdf_in_t;

  typedef struct packed {
    logic signed [23:0] distance;
    logic               saturated;
  } sdf_out_t;

  typedef struct packed {
    logic [43:0] rem;
    logic [21:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned k);
    logic [45:0] trial;
    sqrt_t       r;
    trial = (46'(s.root) << (k + 1)) + (46'd1 << (2 * k));
    r = s;
    if (46'(s.rem) >= trial) begin
      r.rem  = s.rem - trial[43:0];
      r.root = s.root | (22'd1 << k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdf_primitive_distance.sv =====
// Signed distance from a query point to one configured primitive.
// Input channel: in_valid_i / in_stall_o carry one point (x, y, z, signed
// Q8.8) per transaction. Output channel: out_valid_o / out_stall_i carry the
// signed Q15.8 distance and a saturation flag, one result per point, in order.
// Configuration: cfg_valid_i / cfg_ready_o write register cfg_index_i with
// cfg_data_i; ready is always high. Write only while no point is in flight.
// One point is taken every cycle while out_stall_i holds no valid result. The
// depth is set by two chained square-root pipelines of 22 stages each, one
// result bit per stage, plus nine arithmetic stages.
// Reset clears all valid bits and loads the identity rotation, zero origin,
// kind none, major radius 1.0 and minor radius 0.25.
// When out_stall_i holds a valid result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sdf_primitive_distance import sdfpd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire sdf_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sdf_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);

  shape_kind_e kind_q;
  logic [47:0] origin_q;
  logic [47:0] rot_q [3];
  logic [15:0] major_q;
  logic [15:0] minor_q;

  logic                  adv;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] valid_q;

  assign cfg_ready_o = 1'b1;
  assign adv         = !(valid_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign accept      = in_valid_i && adv;
  assign out_valid_o = valid_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_NONE;
      origin_q <= '0;
      rot_q[0] <= 48'h0000_0000_4000;
      rot_q[1] <= 48'h0000_4000_0000;
      rot_q[2] <= 48'h4000_0000_0000;
      major_q  <= 16'd256;
      minor_q  <= 16'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SHAPE_KIND:   kind_q   <= shape_kind_e'(cfg_data_i[1:0]);
        REG_ORIGIN:       origin_q <= cfg_data_i;
        REG_ROT_ROW_ZERO: rot_q[0] <= cfg_data_i;
        REG_ROT_ROW_ONE:  rot_q[1] <= cfg_data_i;
        REG_ROT_ROW_TWO:  rot_q[2] <= cfg_data_i;
        REG_MAJOR_RADIUS: major_q  <= cfg_data_i[15:0];
        REG_MINOR_RADIUS: minor_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // stage 1: origin offset
  shape_kind_e        kind1_q;
  logic signed [16:0] d1_q [3];
  logic signed [15:0] pos [3];

  assign pos[0] = in_data_i.pos_x;
  assign pos[1] = in_data_i.pos_y;
  assign pos[2] = in_data_i.pos_z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= kind_q;
      for (int j = 0; j < 3; j++) begin
        d1_q[j] <= 17'(pos[j]) - 17'($signed(origin_q[16*j +: 16]));
      end
    end
  end

  // stage 2: rotation products
  shape_kind_e        kind2_q;
  logic signed [32:0] p2_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind2_q <= kind1_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_q[i][j] <= 33'($signed(rot_q[i][16*j +: 16])) * 33'(d1_q[j]);
        end
      end
    end
  end

  // stage 3: row sums, round to Q.8
  shape_kind_e        kind3_q;
  logic signed [20:0] l3_q [3];
  logic signed [34:0] acc3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc3[i] = 35'(p2_q[i][0]) + 35'(p2_q[i][1]) + 35'(p2_q[i][2]) + 35'sd8192;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind3_q <= kind2_q;
      for (int i = 0; i < 3; i++) begin
        l3_q[i] <= acc3[i][34:14];
      end
    end
  end

  // stage 4: squares
  shape_kind_e        kind4_q;
  logic signed [20:0] lz4_q;
  logic [41:0]        sq4_q [3];
  logic [20:0]        mag3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag3[i] = l3_q[i][20] ? 21'(-l3_q[i]) : 21'(l3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind4_q <= kind3_q;
      lz4_q   <= l3_q[2];
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= 42'(mag3[i]) * 42'(mag3[i]);
      end
    end
  end

  // stage 5 and first root
  shape_kind_e        kind_r1 [SQRT_STEPS+1];
  logic signed [20:0] lz_r1   [SQRT_STEPS+1];
  logic [41:0]        ly2_r1  [SQRT_STEPS+1];
  sqrt_t              sq_r1   [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_r1[0]     <= kind4_q;
      lz_r1[0]       <= lz4_q;
      ly2_r1[0]      <= sq4_q[1];
      sq_r1[0].root  <= '0;
      sq_r1[0].rem   <= 44'(sq4_q[0]) + 44'(sq4_q[2])
                      + ((kind4_q == KIND_SPHERE) ? 44'(sq4_q[1]) : 44'd0);
    end
  end

  for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_root1
    always_ff @(posedge clk_i) begin
      if (adv) begin
        kind_r1[t+1] <= kind_r1[t];
        lz_r1[t+1]   <= lz_r1[t];
        ly2_r1[t+1]  <= ly2_r1[t];
        sq_r1[t+1]   <= sqrt_step(sq_r1[t], SQRT_STEPS - 1 - t);
      end
    end
  end

  // subtract major radius
  shape_kind_e        kind6_q;
  logic signed [20:0] lz6_q;
  logic [41:0]        ly26_q;
  logic signed [22:0] pre6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind6_q <= kind_r1[SQRT_STEPS];
      lz6_q   <= lz_r1[SQRT_STEPS];
      ly26_q  <= ly2_r1[SQRT_STEPS];
      pre6_q  <= $signed({1'b0, sq_r1[SQRT_STEPS].root}) - $signed({7'b0, major_q});
    end
  end

  // square of ring offset
  shape_kind_e        kind7_q;
  logic signed [20:0] lz7_q;
  logic [41:0]        ly27_q;
  logic signed [22:0] pre7_q;
  logic [45:0]        a27_q;
  logic [22:0]        mag6;

  assign mag6 = pre6_q[22] ? 23'(-pre6_q) : 23'(pre6_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind7_q <= kind6_q;
      lz7_q   <= lz6_q;
      ly27_q  <= ly26_q;
      pre7_q  <= pre6_q;
      a27_q   <= 46'(mag6) * 46'(mag6);
    end
  end

  // stage sum and second root
  shape_kind_e        kind_r2 [SQRT_STEPS+1];
  logic signed [20:0] lz_r2   [SQRT_STEPS+1];
  logic signed [22:0] pre_r2  [SQRT_STEPS+1];
  sqrt_t              sq_r2   [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_r2[0]    <= kind7_q;
      lz_r2[0]      <= lz7_q;
      pre_r2[0]     <= pre7_q;
      sq_r2[0].root <= '0;
      sq_r2[0].rem  <= a27_q[43:0] + 44'(ly27_q);
    end
  end

  for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_root2
    always_ff @(posedge clk_i) begin
      if (adv) begin
        kind_r2[t+1] <= kind_r2[t];
        lz_r2[t+1]   <= lz_r2[t];
        pre_r2[t+1]  <= pre_r2[t];
        sq_r2[t+1]   <= sqrt_step(sq_r2[t], SQRT_STEPS - 1 - t);
      end
    end
  end

  // select and clamp
  logic signed [24:0] dist_raw;
  sdf_out_t           res_d;
  sdf_out_t           out_q;

  always_comb begin
    case (kind_r2[SQRT_STEPS])
      KIND_SPHERE: dist_raw = 25'(pre_r2[SQRT_STEPS]);
      KIND_FLOOR:  dist_raw = 25'(lz_r2[SQRT_STEPS]);
      KIND_TORUS:  dist_raw = $signed({3'b0, sq_r2[SQRT_STEPS].root})
                            - $signed({9'b0, minor_q});
      default:     dist_raw = $signed({1'b0, NONE_DISTANCE});
    endcase
    if (dist_raw > 25'sd8388607) begin
      res_d.distance  = 24'sh7FFFFF;
      res_d.saturated = 1'b1;
    end else if (dist_raw < -25'sd8388608) begin
      res_d.distance  = 24'sh800000;
      res_d.saturated = 1'b1;
    end else begin
      res_d.distance  = dist_raw[23:0];
      res_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_data_o = out_q;

`ifndef NO_ASSERTIONS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_freeze_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(valid_q))
    else $error("pipeline moved while output stalled");

  a_no_clip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_data_o.saturated)
    else $error("distance clipped although range cannot be exceeded");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_sdf_primitive_distance.sv =====
`timescale 1ns / 1ps

module tb_sdf_primitive_distance;
  import sdfpd_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int unsigned DRAIN_CYCLES = PIPE_DEPTH + 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  sdf_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  sdf_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  sdf_in_t     point_q[$];
  sdf_out_t    distance_q[$];
  bit          in_took;
  bit          no_idle;
  int          err_cnt;

  shape_kind_e kind_m;
  logic [47:0] origin_m;
  logic [47:0] rows_m[3];
  logic [15:0] major_m;
  logic [15:0] minor_m;

  sdf_primitive_distance u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint half_s(logic [47:0] packed_v, int k);
    logic signed [15:0] h;
    h = packed_v[16*k +: 16];
    return longint'(h);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic sdf_out_t shape_distance(sdf_in_t p);
    longint   d[3];
    longint   l[3];
    longint   acc;
    longint   dist_v;
    longint   ring;
    sdf_out_t r;
    r.saturated = 1'b0;
    if (kind_m == KIND_NONE) begin
      r.distance = NONE_DISTANCE;
      return r;
    end
    d[0] = longint'(p.pos_x) - half_s(origin_m, 0);
    d[1] = longint'(p.pos_y) - half_s(origin_m, 1);
    d[2] = longint'(p.pos_z) - half_s(origin_m, 2);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += half_s(rows_m[i], j) * d[j];
      l[i] = (acc + 8192) >>> 14;
    end
    case (kind_m)
      KIND_SPHERE: dist_v = root_floor(l[0]*l[0] + l[1]*l[1] + l[2]*l[2]) - longint'(major_m);
      KIND_FLOOR:  dist_v = l[2];
      default: begin
        ring = root_floor(l[0]*l[0] + l[2]*l[2]) - longint'(major_m);
        dist_v = root_floor(ring*ring + l[1]*l[1]) - longint'(minor_m);
      end
    endcase
    if (dist_v > 64'sd8388607) begin
      dist_v = 8388607;
      r.saturated = 1'b1;
    end else if (dist_v < -64'sd8388608) begin
      dist_v = -8388608;
      r.saturated = 1'b1;
    end
    r.distance = dist_v[23:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 6);
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= idle_now();
    if (!in_valid_i || in_took) begin
      if (point_q.size() != 0 && !idle_now()) begin
        in_data_i  <= point_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_m   <= KIND_NONE;
      origin_m <= '0;
      rows_m[0] <= 48'h0000_0000_4000;
      rows_m[1] <= 48'h0000_4000_0000;
      rows_m[2] <= 48'h4000_0000_0000;
      major_m  <= 16'd256;
      minor_m  <= 16'd64;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SHAPE_KIND:   kind_m   <= shape_kind_e'(cfg_data_i[1:0]);
          REG_ORIGIN:       origin_m <= cfg_data_i;
          REG_ROT_ROW_ZERO: rows_m[0] <= cfg_data_i;
          REG_ROT_ROW_ONE:  rows_m[1] <= cfg_data_i;
          REG_ROT_ROW_TWO:  rows_m[2] <= cfg_data_i;
          REG_MAJOR_RADIUS: major_m  <= cfg_data_i[15:0];
          REG_MINOR_RADIUS: minor_m  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        distance_q.push_back(shape_distance(in_data_i));
        in_took = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sdf_out_t want;
        if (distance_q.size() == 0) begin
          $error("unexpected result transaction distance=%0d", out_data_o.distance);
          err_cnt++;
        end else begin
          want = distance_q.pop_front();
          if (out_data_o.distance !== want.distance) begin
            $error("distance: expected %0d actual %0d", want.distance, out_data_o.distance);
            err_cnt++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated: expected %0d actual %0d", want.saturated,
                   out_data_o.saturated);
            err_cnt++;
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (point_q.size() != 0 || in_valid_i || distance_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand_rotation();
    logic [47:0] r;
    r = '0;
    if ($urandom_range(1)) return rand48();
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = 16'($urandom_range(2) == 0 ? 0 :
                          ($urandom_range(1) ? 16384 : -16384));
    return r;
  endfunction

  function automatic sdf_in_t rand_point();
    sdf_in_t p;
    logic [15:0] c[3];
    for (int j = 0; j < 3; j++) begin
      if ($urandom_range(9) < 7)
        c[j] = origin_m[16*j +: 16] + 16'($signed($urandom_range(4095)) - 2048);
      else
        c[j] = 16'($urandom());
    end
    p.pos_x = c[0];
    p.pos_y = c[1];
    p.pos_z = c[2];
    return p;
  endfunction

  task automatic push_directed();
    sdf_in_t p;
    p = '{16'sd0, 16'sd0, 16'sd0};              point_q.push_back(p);
    p = '{16'sd32767, 16'sd32767, 16'sd32767};  point_q.push_back(p);
    p = '{-16'sd32768, -16'sd32768, -16'sd32768}; point_q.push_back(p);
    p = '{16'sd0, -16'sd32768, 16'sd32767};     point_q.push_back(p);
    p = '{16'sd0, 16'sd0, 16'sd256};            point_q.push_back(p);
    p = '{16'sd256, -16'sd256, 16'sd0};         point_q.push_back(p);
  endtask

  initial begin
    logic [47:0] ident[3];
    ident[0] = 48'h0000_0000_4000;
    ident[1] = 48'h0000_4000_0000;
    ident[2] = 48'h4000_0000_0000;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    push_directed();
    wait_idle();
    cfg_write(REG_SHAPE_KIND, 48'(KIND_SPHERE));
    cfg_write(REG_MAJOR_RADIUS, 48'hFFFF_0000_0200);
    push_directed();
    wait_idle();
    cfg_write(REG_SHAPE_KIND, 48'(KIND_FLOOR));
    cfg_write(REG_ROT_ROW_TWO, 48'h8000_8000_8000);
    cfg_write(REG_UNUSED, rand48());
    push_directed();
    wait_idle();
    cfg_write(REG_SHAPE_KIND, 48'(KIND_TORUS));
    cfg_write(REG_ROT_ROW_TWO, ident[2]);
    cfg_write(REG_MAJOR_RADIUS, 48'd512);
    cfg_write(REG_MINOR_RADIUS, 48'd128);
    push_directed();
    wait_idle();

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 0) begin
        for (int r = 0; r < 7; r++) cfg_write(3'(r), '1);
      end else if (ph == 1) begin
        for (int r = 1; r < 7; r++) cfg_write(3'(r), '0);
        cfg_write(REG_SHAPE_KIND, 48'(KIND_TORUS));
      end else begin
        cfg_write(REG_SHAPE_KIND, rand48());
        cfg_write(REG_ORIGIN, rand48());
        cfg_write(REG_ROT_ROW_ZERO, rand_rotation());
        cfg_write(REG_ROT_ROW_ONE, rand_rotation());
        cfg_write(REG_ROT_ROW_TWO, rand_rotation());
        cfg_write(REG_MAJOR_RADIUS, $urandom_range(3) == 0 ? '1 : rand48());
        cfg_write(REG_MINOR_RADIUS, $urandom_range(3) == 0 ? '0 : rand48());
        if ($urandom_range(1)) cfg_write(REG_UNUSED, rand48());
      end
      @(posedge clk_i);
      no_idle = (ph == 5);
      for (int n = 0; n < 80; n++) point_q.push_back(rand_point());
      wait_idle();
      no_idle = 1'b0;
    end

    if (err_cnt == 0 && distance_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sdfpd_pkg.sv
rtl/sdf_primitive_distance.sv
verif/tb_sdf_primitive_distance.sv
